### rtl/msc_pkg.sv
package msc_pkg;

	localparam int NUM_CACHES      = 3;
	localparam int LINES_PER_CACHE = 4;

	localparam int CORE_W = 4;
	localparam int ADDR_W = 16;
	localparam int DATA_W = 32;

	localparam int CW = (NUM_CACHES > 1) ? $clog2(NUM_CACHES) : 1;
	localparam int IW = (LINES_PER_CACHE > 1) ? $clog2(LINES_PER_CACHE) : 1;

	// addr mod LINES_PER_CACHE through a reciprocal: q = (addr * RECIP) >> RECIP_SH,
	// never above the true quotient and at most one below it
	localparam int RECIP_SH = ADDR_W + 7;
	localparam longint RECIP = (longint'(1) << RECIP_SH) / LINES_PER_CACHE;
	localparam int RECIP_W = RECIP_SH + 1;

	typedef enum logic [1:0] {
		ST_M = 2'd0,
		ST_S = 2'd1,
		ST_I = 2'd2
	} line_state_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_RD   = 2'd1,
		OP_RDX  = 2'd2,
		OP_WB   = 2'd3
	} bus_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MOD,
		S_REQ,
		S_SNOOP,
		S_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic                     req_type;
		logic [CORE_W-1:0]        core;
		logic [ADDR_W-1:0]        addr;
		logic signed [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		bus_op_t                  bus_op;
		logic                     from_cache;
		logic [CORE_W-1:0]        supplier_core;
		logic signed [DATA_W-1:0] memory_value;
		line_state_t              requester_state;
		logic signed [DATA_W-1:0] requester_data;
	} res_t;

	typedef struct packed {
		logic capture;
		logic do_div;
		logic do_mod;
		logic do_req;
		logic do_snoop;
		logic load_res;
	} cmd_t;

	typedef struct packed {
		logic need_snoop;
		logic last_snoop;
	} stat_t;

endpackage

### rtl/msc_ctrl.sv
module msc_ctrl
	import msc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  stat_t stat,
	output cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DIV;
				end
			end
			S_DIV: begin
				cmd.do_div = 1'b1;
				state_d    = S_MOD;
			end
			S_MOD: begin
				cmd.do_mod = 1'b1;
				state_d    = S_REQ;
			end
			S_REQ: begin
				cmd.do_req = 1'b1;
				state_d    = stat.need_snoop ? S_SNOOP : S_FIN;
			end
			S_SNOOP: begin
				cmd.do_snoop = 1'b1;
				if (stat.last_snoop) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.load_res = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/msc_datapath.sv
module msc_datapath
	import msc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  request,
	input  cmd_t  cmd,
	output stat_t stat,
	output logic  done,
	output res_t  result
);

	req_t                     req_q;
	logic [ADDR_W-1:0]        quot_q;
	logic [IW-1:0]            idx_q;
	logic [CW-1:0]            snoop_q;
	bus_op_t                  op_q;
	logic                     from_q;
	logic [CORE_W-1:0]        sup_q;
	logic signed [DATA_W-1:0] mem_q;
	res_t                     res_q;
	logic                     done_q;

	line_state_t              st_q   [NUM_CACHES][LINES_PER_CACHE];
	logic                     tv_q   [NUM_CACHES][LINES_PER_CACHE];
	logic [ADDR_W-1:0]        tag_q  [NUM_CACHES][LINES_PER_CACHE];
	logic signed [DATA_W-1:0] data_q [NUM_CACHES][LINES_PER_CACHE];

	logic                     in_range;
	logic [CW-1:0]            req_c;
	logic [CW-1:0]            rd_c;
	line_state_t              rd_st;
	logic signed [DATA_W-1:0] rd_data;
	logic                     rd_hit;

	logic [ADDR_W+RECIP_W-1:0] prod;
	logic [ADDR_W-1:0]         rem_raw;
	logic [ADDR_W-1:0]         rem;

	// requester line update
	bus_op_t                  new_op;
	logic                     req_wr;
	line_state_t              req_st;
	logic signed [DATA_W-1:0] req_data;

	// snooper line update
	logic                     snp_wr;
	line_state_t              snp_st;
	logic                     snp_supply;

	assign in_range = {1'b0, req_q.core} < (CORE_W+1)'(NUM_CACHES);
	assign req_c    = req_q.core[CW-1:0];
	assign rd_c     = cmd.do_snoop ? snoop_q : req_c;
	assign rd_st    = st_q[rd_c][idx_q];
	assign rd_data  = data_q[rd_c][idx_q];
	assign rd_hit   = tv_q[rd_c][idx_q] && (tag_q[rd_c][idx_q] == req_q.addr);

	assign prod    = req_q.addr * (ADDR_W+RECIP_W)'(RECIP);
	assign rem_raw = req_q.addr - ADDR_W'(quot_q * ADDR_W'(LINES_PER_CACHE));
	assign rem     = (rem_raw >= ADDR_W'(LINES_PER_CACHE)) ?
	                 rem_raw - ADDR_W'(LINES_PER_CACHE) : rem_raw;

	always_comb begin
		new_op   = OP_NONE;
		req_wr   = 1'b0;
		req_st   = rd_st;
		req_data = rd_data;
		if (in_range) begin
			if (!req_q.req_type) begin
				if (!(rd_hit && rd_st != ST_I)) begin
					req_wr   = 1'b1;
					req_st   = ST_S;
					req_data = '0;
					new_op   = (rd_st == ST_M) ? OP_WB : OP_RD;
				end
			end else begin
				req_wr   = 1'b1;
				req_data = req_q.write_value;
				if (rd_hit && rd_st == ST_M) begin
					req_st = ST_M;
					new_op = OP_NONE;
				end else if (rd_hit && rd_st == ST_S) begin
					req_st = ST_M;
					new_op = OP_RDX;
				end else begin
					req_st = ST_M;
					new_op = (rd_st == ST_M) ? OP_WB : OP_RDX;
				end
			end
		end
	end

	always_comb begin
		snp_wr     = 1'b0;
		snp_st     = rd_st;
		snp_supply = 1'b0;
		if (4'(snoop_q) != req_q.core && rd_hit) begin
			if (rd_st == ST_M) begin
				snp_wr     = 1'b1;
				snp_supply = 1'b1;
				snp_st     = (op_q == OP_RD) ? ST_S : ST_I;
			end else if (op_q == OP_RDX && rd_st == ST_S) begin
				snp_wr = 1'b1;
				snp_st = ST_I;
			end
		end
	end

	assign stat.need_snoop = new_op inside {OP_RD, OP_RDX};
	assign stat.last_snoop = snoop_q == CW'(NUM_CACHES - 1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
		end
		if (cmd.do_div) begin
			quot_q <= prod[RECIP_SH +: ADDR_W];
		end
		if (cmd.do_mod) begin
			idx_q <= rem[IW-1:0];
		end
		if (cmd.do_req) begin
			op_q    <= new_op;
			from_q  <= 1'b0;
			sup_q   <= '0;
			snoop_q <= '0;
		end
		if (cmd.do_snoop) begin
			snoop_q <= snoop_q + 1'b1;
			if (snp_supply) begin
				from_q <= 1'b1;
				sup_q  <= 4'(snoop_q);
			end
		end
		if (cmd.do_req && req_wr) begin
			tag_q[req_c][idx_q]  <= req_q.addr;
			data_q[req_c][idx_q] <= req_data;
		end
		if (cmd.load_res) begin
			res_q.bus_op          <= op_q;
			res_q.from_cache      <= from_q;
			res_q.supplier_core   <= sup_q;
			res_q.memory_value    <= mem_q;
			res_q.requester_state <= (in_range && rd_hit) ? rd_st : ST_I;
			res_q.requester_data  <= (in_range && rd_hit) ? rd_data : '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_q  <= '0;
			done_q <= 1'b0;
			for (int c = 0; c < NUM_CACHES; c++) begin
				for (int l = 0; l < LINES_PER_CACHE; l++) begin
					st_q[c][l] <= ST_I;
					tv_q[c][l] <= 1'b0;
				end
			end
		end else begin
			done_q <= cmd.load_res;
			if (cmd.do_req && req_wr) begin
				st_q[req_c][idx_q] <= req_st;
				tv_q[req_c][idx_q] <= 1'b1;
			end
			if (cmd.do_snoop && snp_wr) begin
				st_q[snoop_q][idx_q] <= snp_st;
			end
			if (cmd.do_snoop && snp_supply) begin
				mem_q <= rd_data;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

### rtl/msc_top.sv
// channel   signals               direction  handshake
// request   start, busy, request  in         taken when start && !busy
// result    done, result          out        valid for the single cycle done is high
//
// A request passes through capture, two steps of the line-index modulo, requester
// update, a snoop of every cache in turn in the snoop sequencer when it puts BusRd or
// BusRdX on the bus, and result load; done is registered from the result load, and
// the next request may already be taken while done is high.
// Reset clears all line states and tag valids and the memory word at once.
// The result side cannot stall; busy holds off requests while one is in work.
module msi_snooping_coherence_top
	import msc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output res_t result
);

	cmd_t  cmd;
	stat_t stat;

	msc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	msc_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

endmodule

### verif/msc_coherence_sb_pkg.sv
package msc_coherence_sb_pkg;
	import msc_pkg::*;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;
	localparam int   NLINES    = NUM_CACHES * LINES_PER_CACHE;
	localparam int   MAX_REPORTS = 10;

	// Tracks the line stores and the memory word, predicts the outcome of each
	// accepted request and checks the outcomes in order.
	class coherence_ledger;
		line_state_t       line_st[NLINES];
		logic              tag_ok[NLINES];
		logic [ADDR_W-1:0] line_tag[NLINES];
		logic [DATA_W-1:0] line_word[NLINES];
		logic [DATA_W-1:0] mem_word;
		res_t              expected_outcomes[$];
		int                failures;

		function new();
			for (int i = 0; i < NLINES; i++) begin
				line_st[i]   = ST_I;
				tag_ok[i]    = 1'b0;
				line_tag[i]  = '0;
				line_word[i] = '0;
			end
			mem_word = '0;
			failures = 0;
		endfunction

		function bit holds(int slot, logic [ADDR_W-1:0] a);
			return tag_ok[slot] && line_tag[slot] == a;
		endfunction

		function void fill(int slot, logic [ADDR_W-1:0] a, line_state_t st,
				logic [DATA_W-1:0] d);
			line_st[slot]   = st;
			tag_ok[slot]    = 1'b1;
			line_tag[slot]  = a;
			line_word[slot] = d;
		endfunction

		function string fmt(res_t r);
			return $sformatf("op=%0d from_cache=%0d supplier=%0d mem=%h state=%0d data=%h",
				r.bus_op, r.from_cache, r.supplier_core, r.memory_value,
				r.requester_state, r.requester_data);
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("ERROR: %s", msg);
		endfunction

		function int pending();
			return expected_outcomes.size();
		endfunction

		function void note_request(req_t r);
			int idx;
			int slot;
			int s2;
			bit hit;
			bit was_m;
			res_t o;
			o.bus_op          = OP_NONE;
			o.from_cache      = 1'b0;
			o.supplier_core   = '0;
			o.requester_state = ST_I;
			o.requester_data  = '1;
			// out-of-range cores leave everything untouched
			if (r.core < NUM_CACHES) begin
				idx   = r.addr % LINES_PER_CACHE;
				slot  = r.core * LINES_PER_CACHE + idx;
				hit   = holds(slot, r.addr);
				was_m = line_st[slot] == ST_M;
				if (r.req_type == REQ_READ) begin
					if (!(hit && line_st[slot] != ST_I)) begin
						// read fill holds zero, not the memory value
						fill(slot, r.addr, ST_S, '0);
						o.bus_op = was_m ? OP_WB : OP_RD;
					end
				end else if (hit && line_st[slot] == ST_M) begin
					line_word[slot] = r.write_value;
				end else if (hit && line_st[slot] == ST_S) begin
					line_st[slot]   = ST_M;
					line_word[slot] = r.write_value;
					o.bus_op        = OP_RDX;
				end else begin
					fill(slot, r.addr, ST_M, r.write_value);
					o.bus_op = was_m ? OP_WB : OP_RDX;
				end

				// dirty eviction puts only the writeback on the bus: nobody snoops it
				if (o.bus_op == OP_RD || o.bus_op == OP_RDX) begin
					for (int c = 0; c < NUM_CACHES; c++) begin
						s2 = c * LINES_PER_CACHE + idx;
						if (c == r.core || !holds(s2, r.addr))
							continue;
						if (line_st[s2] == ST_M) begin
							line_st[s2]     = (o.bus_op == OP_RD) ? ST_S : ST_I;
							mem_word        = line_word[s2];
							o.from_cache    = 1'b1;
							o.supplier_core = CORE_W'(c);
						end else if (o.bus_op == OP_RDX && line_st[s2] == ST_S) begin
							line_st[s2] = ST_I;
						end
					end
				end

				if (holds(slot, r.addr)) begin
					o.requester_state = line_st[slot];
					o.requester_data  = line_word[slot];
				end
			end
			o.memory_value = mem_word;
			expected_outcomes.push_back(o);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_outcomes.size() == 0) begin
				flag({"result with no request pending: ", fmt(got)});
				return;
			end
			want = expected_outcomes.pop_front();
			if (got.bus_op !== want.bus_op || got.from_cache !== want.from_cache ||
					got.supplier_core !== want.supplier_core ||
					got.memory_value !== want.memory_value ||
					got.requester_state !== want.requester_state ||
					got.requester_data !== want.requester_data)
				flag({"mismatch\n  expected ", fmt(want), "\n  actual   ", fmt(got)});
		endfunction
	endclass

endpackage

### verif/testbench.sv
module testbench;
	import msc_pkg::*;
	import msc_coherence_sb_pkg::*;

	localparam int RANDOM_ITEMS = 750;
	localparam int STALL_LIMIT  = 500;
	localparam int DRAIN_CYCLES = 12;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t request;
	res_t result;

	coherence_ledger ledger;
	int idle_cycles;

	msi_snooping_coherence_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				ledger.note_request(request);
			if (done)
				ledger.check_result(result);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("TIMEOUT: no request or result for %0d cycles", STALL_LIMIT);
		$display("msi_snooping_coherence_top verification failed");
		$finish;
	end

	function automatic req_t make_req(logic kind, int core, int addr, logic [DATA_W-1:0] value);
		req_t r;
		r.req_type    = kind;
		r.core        = CORE_W'(core);
		r.addr        = ADDR_W'(addr);
		r.write_value = value;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int pick;
		r.req_type = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
		if (NUM_CACHES < 16 && $urandom_range(0, 9) == 0)
			r.core = CORE_W'($urandom_range(NUM_CACHES, 15));
		else
			r.core = CORE_W'($urandom_range(0, NUM_CACHES - 1));
		// mostly a small hot set of tags so lines are shared, stolen and evicted
		pick = $urandom_range(0, 19);
		if (pick < 3)
			r.addr = ADDR_W'($urandom);
		else
			r.addr = ADDR_W'($urandom_range(0, 7)) ^ (pick[0] ? 16'hA5F0 : 16'h0000);
		case ($urandom_range(0, 19))
			0: r.write_value = 32'h8000_0000;
			1: r.write_value = 32'h7FFF_FFFF;
			2: r.write_value = '1;
			3: r.write_value = '0;
			default: r.write_value = $urandom;
		endcase
		return r;
	endfunction

	task automatic issue_request(input req_t r);
		request <= r;
		start   <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		int sent;
		int burst;
		ledger      = new();
		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// miss, hit, upgrade, write hit in M
		issue_request(make_req(REQ_READ,  0, 16'h0000, 32'h1234_5678));
		issue_request(make_req(REQ_READ,  0, 16'h0000, 32'h0));
		issue_request(make_req(REQ_WRITE, 0, 16'h0000, 32'h7FFF_FFFF));
		issue_request(make_req(REQ_WRITE, 0, 16'h0000, 32'h8000_0000));
		// dirty owner supplies on a read, then a write invalidates sharers
		issue_request(make_req(REQ_READ,  1, 16'h0000, 32'h0));
		pause(3);
		issue_request(make_req(REQ_WRITE, 2, 16'h0000, 32'hFFFF_FFFF));
		// tag still matches but line is invalid: treated as a miss
		issue_request(make_req(REQ_READ,  0, 16'h0000, 32'h0));
		// fill over an invalid line, then dirty evictions on write and read
		issue_request(make_req(REQ_WRITE, 1, 16'h0004, 32'h1234_5678));
		issue_request(make_req(REQ_WRITE, 1, 16'h0008, 32'h0BAD_F00D));
		issue_request(make_req(REQ_READ,  1, 16'h000C, 32'h0));
		// cores past the cache count are ignored
		issue_request(make_req(REQ_READ,  NUM_CACHES, 16'h0000, 32'h0));
		issue_request(make_req(REQ_WRITE, 15, 16'hFFFF, 32'hFFFF_FFFF));
		issue_request(make_req(REQ_WRITE, 2, 16'hFFFF, 32'h7FFF_FFFF));
		issue_request(make_req(REQ_READ,  0, 16'hFFFF, 32'h0));
		pause(1);
		issue_request(make_req(REQ_WRITE, 1, 16'hFFFF, 32'h0));
		issue_request(make_req(REQ_READ,  2, 16'hFFFF, 32'h0));
		issue_request(make_req(REQ_WRITE, 0, 16'h5555, 32'hAAAA_AAAA));
		issue_request(make_req(REQ_READ,  1, 16'hAAAA, 32'h5555_5555));
		// eviction skips the snoop, leaving two owners of one tag; last supplier wins
		issue_request(make_req(REQ_WRITE, 0, 16'h0020, 32'h1111_1111));
		issue_request(make_req(REQ_WRITE, 1, 16'h0024, 32'h2222_2222));
		issue_request(make_req(REQ_WRITE, 1, 16'h0020, 32'h3333_3333));
		issue_request(make_req(REQ_READ,  2, 16'h0020, 32'h0));
		pause(5);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				issue_request(random_request());
				sent++;
			end
			pause($urandom_range(1, 12));
		end

		start <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.pending() != 0)
			ledger.flag($sformatf("%0d results never arrived", ledger.pending()));
		if (ledger.failures == 0)
			$display("msi_snooping_coherence_top verification clean");
		else
			$display("msi_snooping_coherence_top verification failed");
		$finish;
	end

endmodule
